/* rtl/core/motor_cycle_sequencer_unit_macros.svh */
// Assertion helpers for the motor cycle sequencer.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef MOTOR_CYCLE_SEQUENCER_UNIT_MACROS_SVH
`define MOTOR_CYCLE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define MCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/mcs_pkg.sv */
`default_nettype none

package mcs_pkg;

    // Default widths
    localparam int DUTY_BITS_DEF = 8;
    localparam int TIME_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_DUTY_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FORWARD_DUTY  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE_DUTY  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_TIME     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FORWARD_TIME  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAUSE_TIME    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE_TIME  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COOLDOWN_TIME = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TIME = 3'd7;

    // Register reset values
    localparam int FORWARD_DUTY_RST  = 210;
    localparam int REVERSE_DUTY_RST  = 180;
    localparam int RAMP_TIME_RST     = 1200;
    localparam int FORWARD_TIME_RST  = 5000;
    localparam int PAUSE_TIME_RST    = 800;
    localparam int REVERSE_TIME_RST  = 2000;
    localparam int COOLDOWN_TIME_RST = 4000;
    localparam int DEBOUNCE_TIME_RST = 35;

    // Motor direction codes
    localparam int DIR_BITS = 2;
    localparam logic [DIR_BITS-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_REV  = 2'd2;

    // Phase codes as seen on the result port
    localparam int PHASE_BITS = 4;
    localparam logic [PHASE_BITS-1:0] CODE_IDLE      = 4'd0;
    localparam logic [PHASE_BITS-1:0] CODE_RAMP_FWD  = 4'd1;
    localparam logic [PHASE_BITS-1:0] CODE_RUN_FWD   = 4'd2;
    localparam logic [PHASE_BITS-1:0] CODE_PAUSE     = 4'd3;
    localparam logic [PHASE_BITS-1:0] CODE_RAMP_REV  = 4'd4;
    localparam logic [PHASE_BITS-1:0] CODE_RUN_REV   = 4'd5;
    localparam logic [PHASE_BITS-1:0] CODE_RAMP_DOWN = 4'd6;
    localparam logic [PHASE_BITS-1:0] CODE_COOLDOWN  = 4'd7;
    localparam logic [PHASE_BITS-1:0] CODE_LATCHED   = 4'd8;

    // Motor phase, one-hot
    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_RAMP_FWD  = 9'b000000010,
        PH_RUN_FWD   = 9'b000000100,
        PH_PAUSE     = 9'b000001000,
        PH_RAMP_REV  = 9'b000010000,
        PH_RUN_REV   = 9'b000100000,
        PH_RAMP_DOWN = 9'b001000000,
        PH_COOLDOWN  = 9'b010000000,
        PH_LATCHED   = 9'b100000000
    } t_phase;

    // Controller to datapath commands
    typedef struct packed {
        logic step;
        logic mul;
        logic prep;
        logic div_step;
        logic div_last;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_interp;
    } t_dp_sts;

    function automatic logic [PHASE_BITS-1:0] phase_code(input t_phase ph);
        logic [PHASE_BITS-1:0] code;
        case (ph)
            PH_IDLE:      code = CODE_IDLE;
            PH_RAMP_FWD:  code = CODE_RAMP_FWD;
            PH_RUN_FWD:   code = CODE_RUN_FWD;
            PH_PAUSE:     code = CODE_PAUSE;
            PH_RAMP_REV:  code = CODE_RAMP_REV;
            PH_RUN_REV:   code = CODE_RUN_REV;
            PH_RAMP_DOWN: code = CODE_RAMP_DOWN;
            PH_COOLDOWN:  code = CODE_COOLDOWN;
            PH_LATCHED:   code = CODE_LATCHED;
            default:      code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mcs_interp.sv */
`default_nettype none

// Ramp interpolation: one multiply, then restoring division with
// round-half-up, one quotient bit per cycle.
module mcs_interp
    import mcs_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire t_dp_cmd              i_cmd,
    input  wire logic [TIME_BITS-1:0] i_a,
    input  wire logic [DUTY_BITS-1:0] i_b,
    input  wire logic [TIME_BITS-1:0] i_tot,
    output logic      [DUTY_BITS-1:0] o_quo_next
);

    localparam int NumBits = TIME_BITS + DUTY_BITS;
    localparam int RemBits = NumBits + 2;

    logic [NumBits-1:0]   r_num;
    logic [RemBits-1:0]   r_rem;
    logic [RemBits-1:0]   r_dvs;
    logic [DUTY_BITS-1:0] r_quo;
    logic                 ge;

    // Compare the partial remainder against the shifted divisor
    assign ge         = (r_rem >= r_dvs);
    assign o_quo_next = {r_quo[DUTY_BITS-2:0], ge};

    always_ff @(posedge i_clk) begin
        // Weighted sum of the ramp endpoints
        if (i_cmd.mul) begin
            r_num <= NumBits'(i_a) * NumBits'(i_b);
        end
        // Dividend 2*num + tot, divisor 2*tot aligned to the top quotient bit
        if (i_cmd.prep) begin
            r_rem <= RemBits'({r_num, 1'b0}) + RemBits'(i_tot);
            r_dvs <= RemBits'(i_tot) << DUTY_BITS;
            r_quo <= '0;
        end
        // One quotient bit per step
        if (i_cmd.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_quo <= o_quo_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mcs_dp.sv */
`default_nettype none

module mcs_dp
    import mcs_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                      i_button_pressed,
    input  wire logic                      i_stop_pressed,
    input  wire logic                      i_cat_present,
    input  wire t_dp_cmd                   i_cmd,
    output t_dp_sts                        o_sts,
    output logic      [DIR_BITS-1:0]       o_drive_dir,
    output logic      [DUTY_BITS-1:0]      o_drive_duty,
    output logic      [PHASE_BITS-1:0]     o_phase_code
);

    localparam int DutyLow = (DUTY_BITS < CFG_DUTY_BITS) ? DUTY_BITS : CFG_DUTY_BITS;
    localparam int TimeLow = (TIME_BITS < CFG_DATA_BITS) ? TIME_BITS : CFG_DATA_BITS;

    // Configuration registers
    logic [DUTY_BITS-1:0] r_forward_duty;
    logic [DUTY_BITS-1:0] r_reverse_duty;
    logic [TIME_BITS-1:0] r_ramp_time;
    logic [TIME_BITS-1:0] r_forward_time;
    logic [TIME_BITS-1:0] r_pause_time;
    logic [TIME_BITS-1:0] r_reverse_time;
    logic [TIME_BITS-1:0] r_cooldown_time;
    logic [TIME_BITS-1:0] r_debounce_time;

    // Sequencer state
    t_phase               r_phase;
    logic [TIME_BITS-1:0] r_elapsed;
    logic [TIME_BITS-1:0] r_since_press;
    logic                 r_button_last;
    logic [DIR_BITS-1:0]  r_cur_dir;
    logic [DUTY_BITS-1:0] r_cur_duty;
    logic [DUTY_BITS-1:0] r_ramp_start;

    // Interpolation operands
    logic [TIME_BITS-1:0] r_ia;
    logic [DUTY_BITS-1:0] r_ib;

    t_phase               n_phase;
    logic [TIME_BITS-1:0] n_elapsed;
    logic [TIME_BITS-1:0] n_since_press;
    logic                 n_button_last;
    logic [DIR_BITS-1:0]  n_cur_dir;
    logic [DUTY_BITS-1:0] n_cur_duty;
    logic [DUTY_BITS-1:0] n_ramp_start;
    logic                 n_need;
    logic [TIME_BITS-1:0] n_ia;
    logic [DUTY_BITS-1:0] n_ib;

    logic [DUTY_BITS-1:0] quo_next;

    // Evaluate one tick
    always_comb begin
        logic safe;
        logic btn_edge;
        logic [TIME_BITS-1:0] dt;

        n_phase       = r_phase;
        n_elapsed     = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
        n_since_press = (&r_since_press) ? r_since_press : r_since_press + 1'b1;
        n_button_last = r_button_last;
        n_cur_dir     = r_cur_dir;
        n_cur_duty    = r_cur_duty;
        n_ramp_start  = r_ramp_start;
        n_need        = 1'b0;
        n_ia          = '0;
        n_ib          = '0;
        safe          = !i_cat_present;
        btn_edge      = 1'b0;
        dt            = '0;

        // Latch the emergency stop
        if (i_stop_pressed && (n_phase != PH_LATCHED)) begin
            n_cur_dir  = DIR_STOP;
            n_cur_duty = '0;
            n_phase    = PH_LATCHED;
            n_elapsed  = '0;
        end

        if (n_phase == PH_LATCHED) begin
            // Release to idle once the stop is let go
            if (!i_stop_pressed) begin
                n_phase   = PH_IDLE;
                n_elapsed = '0;
            end
        end else begin
            // Presence forces cooldown
            if (i_cat_present && (n_phase != PH_IDLE) && (n_phase != PH_COOLDOWN)) begin
                n_cur_dir  = DIR_STOP;
                n_cur_duty = '0;
                n_phase    = PH_COOLDOWN;
                n_elapsed  = '0;
            end

            // Debounced press
            if (!r_button_last && i_button_pressed &&
                (n_since_press > r_debounce_time)) begin
                btn_edge      = 1'b1;
                n_since_press = '0;
            end
            n_button_last = i_button_pressed;
            if (btn_edge && (n_phase == PH_IDLE) && safe) begin
                n_phase   = PH_RAMP_FWD;
                n_elapsed = '0;
            end

            dt = n_elapsed;
            case (n_phase)
                PH_IDLE: begin
                    n_cur_dir  = DIR_STOP;
                    n_cur_duty = '0;
                end
                PH_RAMP_FWD: begin
                    if (!safe) begin
                        n_cur_dir  = DIR_STOP;
                        n_cur_duty = '0;
                        n_phase    = PH_COOLDOWN;
                        n_elapsed  = '0;
                    end else begin
                        n_cur_dir = DIR_FWD;
                        if (dt >= r_ramp_time) begin
                            n_cur_duty = r_forward_duty;
                            n_phase    = PH_RUN_FWD;
                            n_elapsed  = '0;
                        end else begin
                            n_need = 1'b1;
                            n_ia   = dt;
                            n_ib   = r_forward_duty;
                        end
                    end
                end
                PH_RUN_FWD: begin
                    if (!safe) begin
                        n_cur_dir  = DIR_STOP;
                        n_cur_duty = '0;
                        n_phase    = PH_COOLDOWN;
                        n_elapsed  = '0;
                    end else if (dt >= r_forward_time) begin
                        n_cur_dir  = DIR_STOP;
                        n_cur_duty = '0;
                        n_phase    = PH_PAUSE;
                        n_elapsed  = '0;
                    end else begin
                        n_cur_dir  = DIR_FWD;
                        n_cur_duty = r_forward_duty;
                    end
                end
                PH_PAUSE: begin
                    n_cur_dir  = DIR_STOP;
                    n_cur_duty = '0;
                    if (dt >= r_pause_time) begin
                        n_phase   = safe ? PH_RAMP_REV : PH_COOLDOWN;
                        n_elapsed = '0;
                    end
                end
                PH_RAMP_REV: begin
                    if (!safe) begin
                        n_cur_dir  = DIR_STOP;
                        n_cur_duty = '0;
                        n_phase    = PH_COOLDOWN;
                        n_elapsed  = '0;
                    end else begin
                        n_cur_dir = DIR_REV;
                        if (dt >= r_ramp_time) begin
                            n_cur_duty = r_reverse_duty;
                            n_phase    = PH_RUN_REV;
                            n_elapsed  = '0;
                        end else begin
                            n_need = 1'b1;
                            n_ia   = dt;
                            n_ib   = r_reverse_duty;
                        end
                    end
                end
                PH_RUN_REV: begin
                    if (!safe) begin
                        n_cur_dir  = DIR_STOP;
                        n_cur_duty = '0;
                        n_phase    = PH_COOLDOWN;
                        n_elapsed  = '0;
                    end else begin
                        n_cur_dir  = DIR_REV;
                        n_cur_duty = r_reverse_duty;
                        // Capture the starting duty of the ramp down
                        if (dt >= r_reverse_time) begin
                            n_ramp_start = r_reverse_duty;
                            n_phase      = PH_RAMP_DOWN;
                            n_elapsed    = '0;
                        end
                    end
                end
                PH_RAMP_DOWN: begin
                    if (dt >= r_ramp_time) begin
                        n_cur_dir  = DIR_STOP;
                        n_cur_duty = '0;
                        n_phase    = PH_COOLDOWN;
                        n_elapsed  = '0;
                    end else begin
                        n_cur_dir = (r_cur_dir == DIR_REV) ? DIR_REV : DIR_FWD;
                        n_need    = 1'b1;
                        n_ia      = r_ramp_time - dt;
                        n_ib      = r_ramp_start;
                    end
                end
                PH_COOLDOWN: begin
                    n_cur_dir  = DIR_STOP;
                    n_cur_duty = '0;
                    if (dt >= r_cooldown_time) begin
                        n_phase   = PH_IDLE;
                        n_elapsed = '0;
                    end
                end
                default: begin
                    n_cur_dir  = DIR_STOP;
                    n_cur_duty = '0;
                    n_phase    = PH_IDLE;
                    n_elapsed  = '0;
                end
            endcase
        end
    end

    assign o_sts.need_interp = n_need;

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward_duty  <= DUTY_BITS'(FORWARD_DUTY_RST);
            r_reverse_duty  <= DUTY_BITS'(REVERSE_DUTY_RST);
            r_ramp_time     <= TIME_BITS'(RAMP_TIME_RST);
            r_forward_time  <= TIME_BITS'(FORWARD_TIME_RST);
            r_pause_time    <= TIME_BITS'(PAUSE_TIME_RST);
            r_reverse_time  <= TIME_BITS'(REVERSE_TIME_RST);
            r_cooldown_time <= TIME_BITS'(COOLDOWN_TIME_RST);
            r_debounce_time <= TIME_BITS'(DEBOUNCE_TIME_RST);
            r_phase         <= PH_IDLE;
            r_elapsed       <= '0;
            r_since_press   <= '0;
            r_button_last   <= 1'b0;
            r_cur_dir       <= DIR_STOP;
            r_cur_duty      <= '0;
            r_ramp_start    <= '0;
        end else begin
            // Take a configuration write
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FORWARD_DUTY:  r_forward_duty  <= DUTY_BITS'(i_cfg_data[DutyLow-1:0]);
                    REG_REVERSE_DUTY:  r_reverse_duty  <= DUTY_BITS'(i_cfg_data[DutyLow-1:0]);
                    REG_RAMP_TIME:     r_ramp_time     <= TIME_BITS'(i_cfg_data[TimeLow-1:0]);
                    REG_FORWARD_TIME:  r_forward_time  <= TIME_BITS'(i_cfg_data[TimeLow-1:0]);
                    REG_PAUSE_TIME:    r_pause_time    <= TIME_BITS'(i_cfg_data[TimeLow-1:0]);
                    REG_REVERSE_TIME:  r_reverse_time  <= TIME_BITS'(i_cfg_data[TimeLow-1:0]);
                    REG_COOLDOWN_TIME: r_cooldown_time <= TIME_BITS'(i_cfg_data[TimeLow-1:0]);
                    REG_DEBOUNCE_TIME: r_debounce_time <= TIME_BITS'(i_cfg_data[TimeLow-1:0]);
                    default: begin
                    end
                endcase
            end
            // Advance the sequencer by one tick
            if (i_cmd.step) begin
                r_phase       <= n_phase;
                r_elapsed     <= n_elapsed;
                r_since_press <= n_since_press;
                r_button_last <= n_button_last;
                r_cur_dir     <= n_cur_dir;
                r_cur_duty    <= n_cur_duty;
                r_ramp_start  <= n_ramp_start;
            end
            // Drop in the interpolated duty
            if (i_cmd.div_last) begin
                r_cur_duty <= quo_next;
            end
        end
    end

    // Interpolation operands and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_ia <= n_ia;
            r_ib <= n_ib;
        end
        if (i_cmd.out_load) begin
            o_drive_dir  <= r_cur_dir;
            o_drive_duty <= r_cur_duty;
            o_phase_code <= phase_code(r_phase);
        end
    end

    mcs_interp #(
        .DUTY_BITS (DUTY_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_interp (
        .i_clk      (i_clk),
        .i_cmd      (i_cmd),
        .i_a        (r_ia),
        .i_b        (r_ib),
        .i_tot      (r_ramp_time),
        .o_quo_next (quo_next)
    );

endmodule

`default_nettype wire

/* rtl/core/mcs_ctrl.sv */
`default_nettype none

`include "motor_cycle_sequencer_unit_macros.svh"

module mcs_ctrl
    import mcs_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam int CntBits = $clog2(DUTY_BITS);
    localparam logic [CntBits-1:0] CntLast = CntBits'(DUTY_BITS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_ctrl_state;

    t_ctrl_state        r_state;
    t_ctrl_state        n_state;
    logic [CntBits-1:0] r_cnt;
    logic               r_valid;

    // Take a request only when idle
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.step     = (r_state == S_IDLE) && i_valid;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.div_last = (r_state == S_DIV) && (r_cnt == CntLast);
        o_cmd.out_load = (r_state == S_OUT) && (!r_valid || !i_stall);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_sts.need_interp ? S_MUL : S_OUT;
                end
            end
            S_MUL:  n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CntLast) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_cmd.out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Count quotient bits
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            // Hold the result until taken
            if (o_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    `MCS_ASSERT_NOW(a_valid_from_out, $rose(r_valid), $past(r_state == S_OUT), "result without out state")
    `MCS_ASSERT_NEXT(a_accept_leaves_idle, i_valid && !o_stall, r_state != S_IDLE, "accept did not start work")
    `MCS_ASSERT_NEXT(a_mul_to_prep, r_state == S_MUL, r_state == S_PREP, "multiply not followed by prep")
    `MCS_ASSERT_NEXT(a_div_ends, o_cmd.div_last, r_state == S_OUT, "divide did not finish")

endmodule

`default_nettype wire

/* rtl/core/motor_cycle_sequencer_unit.sv */
// Motor cycle sequencer: one request per tick, one result per request.
// Flow: a tick without a ramp step goes from the accepting edge straight to the
// output load; when the duty is interpolated it passes through one multiply,
// one setup, the serial divider (one quotient bit per step) and one output load.
// Requests: a new request is taken only once the last result has been loaded
// out (o_stall is high while busy); a result held by i_stall holds off the next request.
// Reset (i_rst_n low, synchronous): idle phase, motor stopped, timers clear.
`default_nettype none

module motor_cycle_sequencer_unit
    import mcs_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_button_pressed,
    input  wire logic                      i_stop_pressed,
    input  wire logic                      i_cat_present,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic      [DIR_BITS-1:0]       o_drive_dir,
    output logic      [DUTY_BITS-1:0]      o_drive_duty,
    output logic      [PHASE_BITS-1:0]     o_phase_code,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration writes always land
    assign o_cfg_ready = 1'b1;

    mcs_ctrl #(
        .DUTY_BITS (DUTY_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mcs_dp #(
        .DUTY_BITS (DUTY_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_button_pressed (i_button_pressed),
        .i_stop_pressed   (i_stop_pressed),
        .i_cat_present    (i_cat_present),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_drive_dir      (o_drive_dir),
        .o_drive_duty     (o_drive_duty),
        .o_phase_code     (o_phase_code)
    );

endmodule

`default_nettype wire
